>>> sv/assert_macros.svh
// Assertion macros shared by the spectrum bar peak-hold RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SBPH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in one cycle that implies a result in the next cycle.
`define SBPH_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) \
    else $error(msg);

`endif

>>> sv/sbph_pkg.sv
// Shared types and constants for the spectrum bar peak-hold block.
// No dependencies; imported by every module of the block.
package sbph_pkg;

  // Field widths
  localparam int MAG_W    = 16;
  localparam int HGT_W    = 4;
  localparam int IDX_O_W  = 4;
  localparam int TERM_W   = 11;
  localparam int SUM_W    = 15;
  localparam int QUO_W    = 13;
  localparam int SCL_W    = 12;
  localparam int PERIOD_W = 8;
  localparam int FRAME_W  = 8;

  // Reciprocal constants: x/10 = (x*0xCCCD)>>19, y/3 = (y*0xAAAB)>>17
  localparam logic [15:0] MAG_RECIP  = 16'hCCCD;
  localparam int          MAG_SHIFT  = 19;
  localparam logic [15:0] DIV3_RECIP = 16'hAAAB;
  localparam int          DIV3_SHIFT = 17;

  localparam logic [SUM_W-1:0]    SUM_MAX       = 15'h7FFF;
  localparam logic [HGT_W-1:0]    LIMIT_LO      = 4'd7;
  localparam logic [HGT_W-1:0]    LIMIT_HI      = 4'd8;
  localparam logic [PERIOD_W-1:0] DEFAULT_DECAY = 8'd20;
  localparam logic [HGT_W-1:0]    PEAK_RESET    = 4'd1;

  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_EN = 2'd3;

  typedef struct packed {
    logic end_bar;
    logic end_frame;
    logic first_bar;
  } sbph_flags_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [PERIOD_W-1:0] rem;
  } sbph_rem_t;

endpackage

>>> sv/spectrum_bar_peak_hold.sv
// Spectrum bar former with peak-hold markers: top level.
// Depends on sbph_pkg, sbph_front, sbph_queue, sbph_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, magnitude_i) takes one FFT magnitude
//   bin per word, bin 0 of a frame first. Bins are summed into bars; when the
//   last bin of a bar is taken, one result word leaves on the output channel
//   (out_valid_o/out_ready_i) with bar index, height, the peak row held before
//   this frame's update, and a last-bar flag. Other bins give no result.
//   Throughput is one bin per cycle while in_ready_o is high. A closing bin
//   passes through the two multiply stages and the queue, then the
//   accumulator and result register.
//   When the receiver stalls, the result register holds; bins keep flowing
//   through the front end into a four-entry queue until it fills, then
//   in_ready_o drops. Configuration writes (cfg_valid_i/cfg_ready_o,
//   cfg_index_i, cfg_data_i) are always taken. A decay_period write rebuilds
//   the frame counter remainder with a bit-serial unit, stalling the back end
//   while it runs.
//   Reset: all peak markers at row 1, frame and bin counters at zero, layout
//   of sixteen bars, height limit 8, decay period 20, peak hold enabled.
module spectrum_bar_peak_hold #(
  parameter int NUM_BINS = 128,
  parameter int MAX_BARS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sbph_pkg::MAG_W-1:0]          magnitude_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sbph_pkg::IDX_O_W-1:0]        bar_index_o,
  output logic [sbph_pkg::HGT_W-1:0]          bar_height_o,
  output logic [sbph_pkg::HGT_W-1:0]          peak_row_o,
  output logic                                last_bar_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sbph_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sbph_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import sbph_pkg::*;

  localparam int PIDX_W = $clog2(MAX_BARS);
  localparam int FLG_W  = $bits(sbph_flags_t);
  localparam int Q_W    = FLG_W + PIDX_W + TERM_W;

  logic                layout_q, lim8_q, peak_en_q;
  logic [PERIOD_W-1:0] period_q;
  logic                cfg_we, rem_start;
  logic [PERIOD_W-1:0] rem_divisor;

  logic                fe_valid, fe_ready;
  logic [TERM_W-1:0]   fe_term, bk_term;
  sbph_flags_t         fe_flags, bk_flags;
  logic [PIDX_W-1:0]   fe_idx, bk_idx;
  logic [Q_W-1:0]      q_wdata, q_rdata;
  logic                q_valid, q_pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q  <= 1'b0;
      lim8_q    <= 1'b1;
      period_q  <= DEFAULT_DECAY;
      peak_en_q <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_LAYOUT:  layout_q  <= cfg_data_i[0];
        // only the low four bits count: limits below 7 act as 7, above 8 as 8
        CFG_LIMIT:   lim8_q    <= (cfg_data_i[HGT_W-1:0] >= LIMIT_HI);
        CFG_DECAY:   period_q  <= cfg_data_i;
        CFG_PEAK_EN: peak_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Rebuild frame count mod period on every period write; zero acts as one
  assign rem_start   = cfg_we && (cfg_index_i == CFG_DECAY);
  assign rem_divisor = (cfg_data_i == '0) ? PERIOD_W'(1) : cfg_data_i;

  sbph_front #(
    .NUM_BINS (NUM_BINS),
    .MAX_BARS (MAX_BARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .layout_i    (layout_q),
    .lim8_i      (lim8_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .magnitude_i (magnitude_i),
    .fe_valid_o  (fe_valid),
    .fe_ready_i  (fe_ready),
    .term_o      (fe_term),
    .flags_o     (fe_flags),
    .idx_o       (fe_idx)
  );

  assign q_wdata = {fe_flags, fe_idx, fe_term};
  assign {bk_flags, bk_idx, bk_term} = q_rdata;

  sbph_queue #(
    .W (Q_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fe_valid),
    .push_ready_o (fe_ready),
    .wdata_i      (q_wdata),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .rdata_o      (q_rdata)
  );

  sbph_back #(
    .MAX_BARS (MAX_BARS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .layout_i      (layout_q),
    .lim8_i        (lim8_q),
    .period_i      (period_q),
    .peak_en_i     (peak_en_q),
    .rem_start_i   (rem_start),
    .rem_divisor_i (rem_divisor),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .term_i        (bk_term),
    .flags_i       (bk_flags),
    .idx_i         (bk_idx),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bar_index_o   (bar_index_o),
    .bar_height_o  (bar_height_o),
    .peak_row_o    (peak_row_o),
    .last_bar_o    (last_bar_o)
  );

endmodule

>>> sv/sbph_rem.sv
// Bit-serial remainder unit: frame count modulo decay period.
// Uses sbph_pkg; one quotient bit per cycle, result flagged by done.
module sbph_rem (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sbph_pkg::FRAME_W-1:0]      dividend_i,
  input  logic [sbph_pkg::PERIOD_W-1:0]     divisor_i,
  output sbph_pkg::sbph_rem_t               status_o
);
  import sbph_pkg::*;

  localparam int STEPS = FRAME_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                busy_q, done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [FRAME_W-1:0]  dvd_q;
  logic [PERIOD_W-1:0] dvs_q;
  logic [PERIOD_W-1:0] r_q;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W-1:0] r_d;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {r_q, dvd_q[FRAME_W-1]};
  assign r_d   = (trial >= {1'b0, dvs_q}) ? PERIOD_W'(trial - {1'b0, dvs_q})
                                          : PERIOD_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      r_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[FRAME_W-2:0], 1'b0};
      r_q   <= r_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.rem  = r_q;

endmodule

>>> sv/sbph_front.sv
// Front end: accepts magnitude words, tracks bar and frame position,
// and scales each bin through a two-stage multiply pipeline. Uses sbph_pkg.
module sbph_front #(
  parameter int NUM_BINS = 128,
  parameter int MAX_BARS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              layout_i,
  input  logic                              lim8_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sbph_pkg::MAG_W-1:0]        magnitude_i,
  output logic                              fe_valid_o,
  input  logic                              fe_ready_i,
  output logic [sbph_pkg::TERM_W-1:0]       term_o,
  output sbph_pkg::sbph_flags_t             flags_o,
  output logic [$clog2(MAX_BARS)-1:0]       idx_o
);
  import sbph_pkg::*;

  localparam int BPB0   = (NUM_BINS / MAX_BARS > 0) ? NUM_BINS / MAX_BARS : 1;
  localparam int BPB1   = 2 * BPB0;
  localparam int NB0    = MAX_BARS;
  localparam int NB1    = (MAX_BARS / 2 > 0) ? MAX_BARS / 2 : 1;
  localparam int FLEN0  = NB0 * BPB0;
  localparam int FLEN1  = NB1 * BPB1;
  localparam int FLENM  = (FLEN0 > FLEN1) ? FLEN0 : FLEN1;
  localparam int BC_W   = $clog2(FLENM);
  localparam int POS0_W = (BPB0 > 1) ? $clog2(BPB0) : 1;
  localparam int POS1_W = $clog2(BPB1);
  localparam int IMAX0  = (FLENM - 1) / BPB0;
  localparam int IMAX1  = (FLENM - 1) / BPB1;
  localparam int IDX0_W = (IMAX0 > 0) ? $clog2(IMAX0 + 1) : 1;
  localparam int IDX1_W = (IMAX1 > 0) ? $clog2(IMAX1 + 1) : 1;
  localparam int PIDX_W = $clog2(MAX_BARS);
  localparam int PROD1_W = MAG_SHIFT + QUO_W;
  localparam int PROD2_W = DIV3_SHIFT + TERM_W;

  // Position counters for both layouts: pos = bin mod width, idx = bin / width
  logic [BC_W-1:0]   bin_q;
  logic [POS0_W-1:0] pos0_q;
  logic [POS1_W-1:0] pos1_q;
  logic [IDX0_W-1:0] idx0_q;
  logic [IDX1_W-1:0] idx1_q;

  logic              accept;
  logic              end_frame, end_bar;
  logic [PIDX_W-1:0] idx_sel;
  sbph_flags_t       flags_in;
  logic [PROD1_W-1:0] prod1;

  logic              s1_v_q, s2_v_q;
  logic [QUO_W-1:0]  s1_quo_q;
  sbph_flags_t       s1_flags_q, s2_flags_q;
  logic [PIDX_W-1:0] s1_idx_q, s2_idx_q;
  logic [TERM_W-1:0] s2_term_q;
  logic              s1_adv, s2_adv;

  logic [QUO_W+2:0]   scaled;
  logic [SCL_W-1:0]   scl;
  logic [PROD2_W-1:0] prod2;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    if (layout_i) begin
      end_frame = (int'(bin_q) + 1) >= FLEN1;
      end_bar   = end_frame || (pos1_q == POS1_W'(BPB1 - 1));
      idx_sel   = (int'(idx1_q) >= NB1) ? PIDX_W'(NB1 - 1) : PIDX_W'(idx1_q);
    end else begin
      end_frame = (int'(bin_q) + 1) >= FLEN0;
      end_bar   = end_frame || (pos0_q == POS0_W'(BPB0 - 1));
      idx_sel   = (int'(idx0_q) >= NB0) ? PIDX_W'(NB0 - 1) : PIDX_W'(idx0_q);
    end
  end

  assign flags_in.end_bar   = end_bar;
  assign flags_in.end_frame = end_frame;
  assign flags_in.first_bar = (idx_sel == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q  <= '0;
      pos0_q <= '0;
      pos1_q <= '0;
      idx0_q <= '0;
      idx1_q <= '0;
    end else if (accept) begin
      if (end_frame) begin
        bin_q  <= '0;
        pos0_q <= '0;
        pos1_q <= '0;
        idx0_q <= '0;
        idx1_q <= '0;
      end else begin
        bin_q <= bin_q + BC_W'(1);
        if (pos0_q == POS0_W'(BPB0 - 1)) begin
          pos0_q <= '0;
          idx0_q <= idx0_q + IDX0_W'(1);
        end else begin
          pos0_q <= pos0_q + POS0_W'(1);
        end
        if (pos1_q == POS1_W'(BPB1 - 1)) begin
          pos1_q <= '0;
          idx1_q <= idx1_q + IDX1_W'(1);
        end else begin
          pos1_q <= pos1_q + POS1_W'(1);
        end
      end
    end
  end

  // Stage 1: magnitude / 10
  assign prod1 = PROD1_W'(magnitude_i) * PROD1_W'(MAG_RECIP);

  // Stage 2: times the limit (7 or 8), then / 48 as >>4 and / 3
  assign scaled = lim8_i ? {s1_quo_q, 3'b000}
                         : ({s1_quo_q, 3'b000} - {3'b000, s1_quo_q});
  assign scl    = scaled[QUO_W+2:4];
  assign prod2  = PROD2_W'(scl) * PROD2_W'(DIV3_RECIP);

  assign s2_adv     = !s2_v_q || fe_ready_i;
  assign s1_adv     = !s1_v_q || s2_adv;
  assign in_ready_o = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_adv) s1_v_q <= in_valid_i;
      if (s2_adv) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_quo_q   <= prod1[PROD1_W-1:MAG_SHIFT];
      s1_flags_q <= flags_in;
      s1_idx_q   <= idx_sel;
    end
    if (s2_adv && s1_v_q) begin
      s2_term_q  <= prod2[PROD2_W-1:DIV3_SHIFT];
      s2_flags_q <= s1_flags_q;
      s2_idx_q   <= s1_idx_q;
    end
  end

  assign fe_valid_o = s2_v_q;
  assign term_o     = s2_term_q;
  assign flags_o    = s2_flags_q;
  assign idx_o      = s2_idx_q;

endmodule

>>> sv/sbph_queue.sv
// Small FIFO between front and back ends of the bar former.
// Uses sbph_pkg for its depth; register array with count.
`include "assert_macros.svh"

module sbph_queue #(
  parameter int W = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         push_ready_o,
  input  logic [W-1:0] wdata_i,
  output logic         pop_valid_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o
);
  import sbph_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [W-1:0]     mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign rdata_o      = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  `SBPH_ASSERT(a_pop_nonempty, pop_i |-> count_q != '0, "queue popped while empty")
  `SBPH_ASSERT(a_count_range, count_q <= CNT_W'(QUEUE_DEPTH), "queue count above depth")

endmodule

>>> sv/sbph_back.sv
// Back end: accumulates scaled bins into bars, forms heights, keeps the
// peak markers and frame counter, and holds the result word. Uses sbph_pkg, sbph_rem.
`include "assert_macros.svh"

module sbph_back #(
  parameter int MAX_BARS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              layout_i,
  input  logic                              lim8_i,
  input  logic [sbph_pkg::PERIOD_W-1:0]     period_i,
  input  logic                              peak_en_i,
  input  logic                              rem_start_i,
  input  logic [sbph_pkg::PERIOD_W-1:0]     rem_divisor_i,
  input  logic                              q_valid_i,
  output logic                              q_pop_o,
  input  logic [sbph_pkg::TERM_W-1:0]       term_i,
  input  sbph_pkg::sbph_flags_t             flags_i,
  input  logic [$clog2(MAX_BARS)-1:0]       idx_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sbph_pkg::IDX_O_W-1:0]      bar_index_o,
  output logic [sbph_pkg::HGT_W-1:0]        bar_height_o,
  output logic [sbph_pkg::HGT_W-1:0]        peak_row_o,
  output logic                              last_bar_o
);
  import sbph_pkg::*;

  localparam int PIDX_W = $clog2(MAX_BARS);

  logic [HGT_W-1:0]    peak_q [MAX_BARS];
  logic [FRAME_W-1:0]  fc_q, fc_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0]    bar_sum_q;
  logic                out_valid_q;
  logic [IDX_O_W-1:0]  out_idx_q;
  logic [HGT_W-1:0]    out_hgt_q, out_peak_q;
  logic                out_last_q;

  sbph_rem_t           rem_st;
  logic [HGT_W-1:0]    limit;
  logic [PERIOD_W-1:0] period_eff;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    sum, half;
  logic [SUM_W-1:0]    first_thr;
  logic [8:0]          x11;
  logic [HGT_W-1:0]    hgt, peak_rd, peak_new;
  logic [HGT_W:0]      hgt2;
  logic                rise, fall;
  logic                out_free, pop;
  logic [FRAME_W-1:0]  fc1;
  logic [PERIOD_W-1:0] rem1, rem_inc;

  sbph_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start_i),
    .dividend_i (fc_q),
    .divisor_i  (rem_divisor_i),
    .status_o   (rem_st)
  );

  assign limit      = lim8_i ? LIMIT_HI : LIMIT_LO;
  assign period_eff = (period_i == '0) ? PERIOD_W'(1) : period_i;
  assign first_thr  = lim8_i ? SUM_W'(3 * int'(LIMIT_HI)) : SUM_W'(3 * int'(LIMIT_LO));

  // Saturating accumulate
  assign sum_ext = {1'b0, bar_sum_q} + (SUM_W + 1)'(term_i);
  assign sum     = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  assign half    = layout_i ? {1'b0, sum[SUM_W-1:1]} : sum;

  // Below the clamp threshold the first bar is under 24, so /3 is (x*11)>>5
  assign x11 = ({4'b0000, half[4:0]} << 3) + ({4'b0000, half[4:0]} << 1)
             + {4'b0000, half[4:0]};

  always_comb begin
    if (flags_i.first_bar) begin
      hgt = (half >= first_thr) ? limit : x11[8:5];
    end else begin
      hgt = (half >= SUM_W'(limit)) ? limit : half[HGT_W-1:0];
    end
  end

  assign peak_rd  = peak_q[idx_i];
  assign hgt2     = {1'b0, hgt} + (HGT_W + 1)'(2);
  assign rise     = (peak_rd <= hgt);
  assign fall     = !rise && (peak_rd >= HGT_W'(2)) && (rem_q == '0);
  assign peak_new = rise ? ((hgt2 > {1'b0, limit}) ? limit : hgt2[HGT_W-1:0])
                         : peak_rd - HGT_W'(1);

  // Frame counter and its remainder modulo the decay period
  always_comb begin
    fc1     = fall ? '0 : fc_q;
    rem1    = fall ? '0 : rem_q;
    rem_inc = rem1 + PERIOD_W'(1);
    fc_d    = fc1;
    rem_d   = rem1;
    if (flags_i.end_frame) begin
      fc_d = fc1 + FRAME_W'(1);
      if (fc1 == '1 || rem_inc == period_eff) begin
        rem_d = '0;
      end else begin
        rem_d = rem_inc;
      end
    end
  end

  // Hold the queue while the remainder is being rebuilt, and hold a closing bin while the result is stalled
  assign out_free = !out_valid_q || out_ready_i;
  assign pop      = q_valid_i && !rem_st.busy && !rem_st.done
                 && (!flags_i.end_bar || out_free);
  assign q_pop_o  = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BARS; i++) begin
        peak_q[i] <= PEAK_RESET;
      end
      fc_q        <= '0;
      rem_q       <= '0;
      bar_sum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rem_st.done) rem_q <= rem_st.rem;
      if (pop && flags_i.end_bar) begin
        out_valid_q <= 1'b1;
        bar_sum_q   <= '0;
        if (peak_en_i) begin
          if (rise || fall) peak_q[idx_i] <= peak_new;
          fc_q  <= fc_d;
          rem_q <= rem_d;
        end
      end else begin
        if (out_ready_i) out_valid_q <= 1'b0;
        if (pop) bar_sum_q <= sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && flags_i.end_bar) begin
      out_idx_q  <= IDX_O_W'(idx_i);
      out_hgt_q  <= hgt;
      out_peak_q <= peak_rd;
      out_last_q <= flags_i.end_frame;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bar_index_o  = out_idx_q;
  assign bar_height_o = out_hgt_q;
  assign peak_row_o   = out_peak_q;
  assign last_bar_o   = out_last_q;

  `SBPH_ASSERT(a_peak_nonzero, pop && flags_i.end_bar |-> peak_rd != '0, "peak marker read as zero")
  `SBPH_ASSERT(a_rem_range, !rem_st.busy && !rem_st.done |-> rem_q < period_eff, "frame remainder not below period")
  `SBPH_ASSERT(a_no_overwrite, out_valid_q && !out_ready_i |-> !(pop && flags_i.end_bar), "result overwritten while stalled")
  `SBPH_ASSERT_NEXT(a_rem_starts, rem_start_i, rem_st.busy && !pop, "remainder rebuild did not hold the back end")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for spectrum_bar_peak_hold: random and directed magnitude bins,
// with a bar and peak-marker predictor checked against every result word.
// Depends on sbph_pkg and the spectrum_bar_peak_hold RTL.
module tb_top;
  import sbph_pkg::*;

  localparam int NUM_BINS          = 128;
  localparam int NUM_BARS          = 16;
  localparam int MAG_DIVISOR       = 10;
  localparam int SCALE_DIVISOR     = 48;
  localparam int FIRST_BAR_DIVISOR = 3;
  localparam int NUM_PHASES        = 12;
  localparam int PRESS_PHASE       = 9;
  localparam int PRESS_LEN         = 80;
  localparam int SETTLE_CYCLES     = 8;
  localparam int STALL_LIMIT       = 2000;

  typedef struct packed {
    logic [IDX_O_W-1:0] bar_idx;
    logic [HGT_W-1:0]   height;
    logic [HGT_W-1:0]   peak;
    logic               last_flag;
  } bar_word_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [MAG_W-1:0]      magnitude_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [IDX_O_W-1:0]    bar_index_o;
  logic [HGT_W-1:0]      bar_height_o;
  logic [HGT_W-1:0]      peak_row_o;
  logic                  last_bar_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Register mirror, reset values
  logic                cfg_layout  = 1'b0;
  logic [HGT_W-1:0]    cfg_limit   = LIMIT_HI;
  logic [PERIOD_W-1:0] cfg_decay   = DEFAULT_DECAY;
  logic                cfg_peak_en = 1'b1;

  // Predicted block state
  logic [HGT_W-1:0]   peak_rows [NUM_BARS];
  logic [FRAME_W-1:0] frames_seen = '0;
  int unsigned        bin_pos     = 0;
  int unsigned        bar_acc     = 0;

  logic [MAG_W-1:0] bin_backlog [$];
  bar_word_t        bar_expect [$];
  bar_word_t        next_bar;
  bar_word_t        want;

  int phase_no      = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int press_cycles  = 0;
  int idle_cycles   = 0;
  int bins_sent     = 0;
  int bars_checked  = 0;
  int frames_closed = 0;
  int cfg_writes    = 0;
  int mismatches    = 0;

  spectrum_bar_peak_hold dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .magnitude_i  (magnitude_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bar_index_o  (bar_index_o),
    .bar_height_o (bar_height_o),
    .peak_row_o   (peak_row_o),
    .last_bar_o   (last_bar_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Add one bin to the running bar; return 1 with the bar word when the bin closes a bar.
  function automatic bit accumulate_bin(input logic [MAG_W-1:0] mag, output bar_word_t res);
    int unsigned lim, period, bpb, nbars, flen, sum, idx, h, pk;
    bit          end_frame, end_bar;
    res    = '0;
    lim    = cfg_limit;
    if (lim < LIMIT_LO) lim = LIMIT_LO;
    if (lim > LIMIT_HI) lim = LIMIT_HI;
    period = (cfg_decay == 0) ? 1 : cfg_decay;
    bpb    = NUM_BINS / NUM_BARS;
    nbars  = NUM_BARS;
    if (cfg_layout) begin
      bpb   = bpb * 2;
      nbars = NUM_BARS / 2;
    end
    flen = nbars * bpb;

    sum = bar_acc + (mag / MAG_DIVISOR) * lim / SCALE_DIVISOR;
    if (sum > SUM_MAX) sum = SUM_MAX;

    end_frame = (bin_pos + 1) >= flen;
    end_bar   = end_frame || (bin_pos % bpb) == bpb - 1;
    if (!end_bar) begin
      bar_acc = sum;
      bin_pos++;
      return 1'b0;
    end

    idx = bin_pos / bpb;
    if (idx >= nbars) idx = nbars - 1;
    h = sum;
    if (cfg_layout) h = h / 2;
    if (idx == 0) h = h / FIRST_BAR_DIVISOR;
    if (h > lim) h = lim;

    pk            = peak_rows[idx];
    res.bar_idx   = idx[IDX_O_W-1:0];
    res.height    = h[HGT_W-1:0];
    res.peak      = pk[HGT_W-1:0];
    res.last_flag = end_frame;

    if (cfg_peak_en) begin
      if (pk <= h) begin
        peak_rows[idx] = (h + 2 > lim) ? lim[HGT_W-1:0] : HGT_W'(h + 2);
      end else if (pk >= 2 && (frames_seen % period) == 0) begin
        // a fall clears the frame count, so later bars of this frame may fall too
        peak_rows[idx] = HGT_W'(pk - 1);
        frames_seen    = '0;
      end
      if (end_frame) frames_seen = frames_seen + 1'b1;
    end

    bar_acc = 0;
    bin_pos = end_frame ? 0 : bin_pos + 1;
    return 1'b1;
  endfunction

  // Sender: offer backlog words, predict on each accepted bin
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      magnitude_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        bins_sent++;
        if (accumulate_bin(magnitude_i, next_bar)) bar_expect.push_back(next_bar);
      end
      if (!in_valid_i || in_ready_o) begin
        if (bin_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          magnitude_i <= bin_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result word, stall at random, hold off once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (bar_expect.size() == 0) begin
          $error("unexpected bar word: bar_index %0d", bar_index_o);
          mismatches++;
        end else begin
          want = bar_expect.pop_front();
          bars_checked++;
          if (want.last_flag) frames_closed++;
          if (bar_index_o !== want.bar_idx) begin
            $error("bar_index: expected %0d, got %0d", want.bar_idx, bar_index_o);
            mismatches++;
          end
          if (bar_height_o !== want.height) begin
            $error("bar_height: expected %0d, got %0d", want.height, bar_height_o);
            mismatches++;
          end
          if (peak_row_o !== want.peak) begin
            $error("peak_row: expected %0d, got %0d", want.peak, peak_row_o);
            mismatches++;
          end
          if (last_bar_o !== want.last_flag) begin
            $error("last_bar: expected %0d, got %0d", want.last_flag, last_bar_o);
            mismatches++;
          end
        end
      end
      if (phase_no == PRESS_PHASE && press_cycles < PRESS_LEN) begin
        press_cycles++;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any accepted word on any channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_LAYOUT:  cfg_layout  = data[0];
      CFG_LIMIT:   cfg_limit   = data[HGT_W-1:0];
      CFG_DECAY:   cfg_decay   = data;
      CFG_PEAK_EN: cfg_peak_en = data[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Wait for the backlog and all bar words to drain, then let bins without results settle
  task automatic wait_idle();
    while (bin_backlog.size() != 0 || in_valid_i || bar_expect.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Runs of eight bins share a level so heights spread over the whole range; a tenth are noise
  task automatic queue_bins(input int n);
    int level;
    level = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 8 == 0) level = $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) bin_backlog.push_back(MAG_W'($urandom()));
      else bin_backlog.push_back(MAG_W'($urandom_range(0, level * 16)));
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lay, lim, dec, en;
    logic [MAG_W-1:0]      directed [24];
    // full-scale bar, silent bar, then values at the divide-by-ten and scale edges
    directed = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                 16'd9, 16'd10, 16'd59, 16'd60, 16'd479, 16'd480, 16'h5555, 16'hAAAA};
    foreach (peak_rows[i]) peak_rows[i] = PEAK_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: begin lay = 8'd1; lim = 8'd7;   dec = 8'd1;   en = 8'd1; end
          // limit 15 acts as 8, decay 0 acts as 1
          2: begin lay = 8'd0; lim = 8'hFF;  dec = 8'd0;   en = 8'd1; end
          // limit 0 acts as 7; freeze the peaks
          3: begin lay = 8'd1; lim = 8'h00;  dec = 8'd255; en = 8'd0; end
          4: begin lay = 8'd0; lim = 8'd8;   dec = 8'd2;   en = 8'd1; end
          default: begin
            lay = {7'($urandom()), 1'($urandom_range(0, 1))};
            lim = 8'($urandom_range(0, 255));
            dec = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 5));
            en  = {7'($urandom()), 1'($urandom_range(0, 4) != 0)};
          end
        endcase
        cfg_write(CFG_LAYOUT, lay);
        cfg_write(CFG_LIMIT, lim);
        cfg_write(CFG_DECAY, dec);
        cfg_write(CFG_PEAK_EN, en);
        cfg_valid_i <= 1'b0;
      end
      phase_no      <= p;
      send_idle_pct <= (p < 4) ? 27 : (p < 8) ? 57 : 0;
      recv_idle_pct <= (p < 4) ? 57 : (p < 8) ? 27 : 0;
      if (p == 0) foreach (directed[i]) bin_backlog.push_back(directed[i]);
      // phase lengths are not whole frames, so layout changes land mid-frame
      queue_bins((p == 0) ? 130 : $urandom_range(115, 175));
    end

    wait_idle();
    if (bar_expect.size() != 0) begin
      $error("%0d bar words never arrived", bar_expect.size());
      mismatches++;
    end
    $display("Sent %0d bins over %0d register settings (%0d writes), both layouts.",
             bins_sent, NUM_PHASES, cfg_writes);
    $display("Checked %0d bar words, %0d frame ends; %0d mismatches.",
             bars_checked, frames_closed, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> spectrum_bar_peak_hold.f
+incdir+sv
sv/sbph_pkg.sv
sv/sbph_rem.sv
sv/sbph_front.sv
sv/sbph_queue.sv
sv/sbph_back.sv
sv/spectrum_bar_peak_hold.sv
tb/sv/tb_top.sv
